/* sv/ptp_pkg.sv */
`timescale 1ns / 1ps

package ptp_pkg;

  // Coordinate format and derived datapath widths.
  localparam int unsigned CoordFracBits = 16;
  localparam int unsigned DetW          = 124;
  localparam int unsigned AlphaDivW     = 123;
  localparam int unsigned FracBits      = 30;
  localparam int unsigned RootBits      = 34;
  localparam int unsigned NrmDivW       = 36;
  localparam int unsigned NrmSteps      = 31;

  // Barycentric constants with 30 fraction bits (Q0.30, MarginHi Q1.30).
  localparam logic [29:0] AlphaHalf = 30'd536870912;
  localparam logic [29:0] MarginLo  = 30'd1074;
  localparam logic [30:0] MarginHi  = 31'd1073740750;

  // Register reset values.
  localparam logic [30:0] AlarmReset   = 31'd65536;
  localparam logic [30:0] ContactReset = 31'd32768;

  // Near-zero determinant limits, one for each common pre-shift.
  localparam logic [DetW-1:0] DetThr0 =
    DetW'((128'd1 << (4 * (CoordFracBits - 0))) / 128'd1000000);
  localparam logic [DetW-1:0] DetThr1 =
    DetW'((128'd1 << (4 * (CoordFracBits - 1))) / 128'd1000000);
  localparam logic [DetW-1:0] DetThr2 =
    DetW'((128'd1 << (4 * (CoordFracBits - 2))) / 128'd1000000);
  localparam logic [DetW-1:0] DetThr3 =
    DetW'((128'd1 << (4 * (CoordFracBits - 3))) / 128'd1000000);
  localparam logic [DetW-1:0] DetThr4 =
    DetW'((128'd1 << (4 * (CoordFracBits - 4))) / 128'd1000000);

  function automatic logic [DetW-1:0] det_thr(input logic [2:0] s);
    logic [DetW-1:0] t;
    unique case (s)
      3'd0:    t = DetThr0;
      3'd1:    t = DetThr1;
      3'd2:    t = DetThr2;
      3'd3:    t = DetThr3;
      default: t = DetThr4;
    endcase
    return t;
  endfunction

  // Configuration register indexes.
  typedef enum logic [0:0] {
    RegAlarm   = 1'b0,
    RegContact = 1'b1
  } ptp_reg_e;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] vertex_a_x;
    logic signed [31:0] vertex_a_y;
    logic signed [31:0] vertex_a_z;
    logic signed [31:0] vertex_b_x;
    logic signed [31:0] vertex_b_y;
    logic signed [31:0] vertex_b_z;
    logic signed [31:0] vertex_c_x;
    logic signed [31:0] vertex_c_y;
    logic signed [31:0] vertex_c_z;
  } ptp_in_t;

  typedef struct packed {
    logic               contact_valid;
    logic               near_alarm;
    logic signed [31:0] closest_x;
    logic signed [31:0] closest_y;
    logic signed [31:0] closest_z;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic signed [31:0] signed_gap;
  } ptp_out_t;

endpackage

/* sv/ptp_delay.sv */
`timescale 1ns / 1ps

module ptp_delay import ptp_pkg::*; #(
  parameter int unsigned W = 8,
  parameter int unsigned N = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         vld_i,
  input  logic [W-1:0] dat_i,
  output logic         vld_o,
  output logic [W-1:0] dat_o
);

  logic         vld_q [N];
  logic [W-1:0] dat_q [N];

  // Valid bits are control state and are cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < N; k++) vld_q[k] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
      for (int k = 1; k < N; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  // Payload moves with its valid bit.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dat_q[0] <= dat_i;
      for (int k = 1; k < N; k++) dat_q[k] <= dat_q[k-1];
    end
  end

  assign vld_o = vld_q[N-1];
  assign dat_o = dat_q[N-1];

endmodule

/* sv/ptp_mul.sv */
`timescale 1ns / 1ps

module ptp_mul import ptp_pkg::*; (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [63:0]  a_i,
  input  logic signed [63:0]  b_i,
  output logic signed [127:0] p_o
);

  logic [63:0]  mag_a, mag_b;
  logic [63:0]  pp00_q, pp01_q, pp10_q, pp11_q;
  logic         neg_q;
  logic [127:0] sum;

  // First stage: magnitudes split into halves, four partial products.
  assign mag_a = a_i[63] ? 64'(-a_i) : 64'(a_i);
  assign mag_b = b_i[63] ? 64'(-b_i) : 64'(b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp00_q <= 64'(mag_a[31:0]) * 64'(mag_b[31:0]);
      pp01_q <= 64'(mag_a[31:0]) * 64'(mag_b[63:32]);
      pp10_q <= 64'(mag_a[63:32]) * 64'(mag_b[31:0]);
      pp11_q <= 64'(mag_a[63:32]) * 64'(mag_b[63:32]);
      neg_q  <= a_i[63] ^ b_i[63];
    end
  end

  // Second stage: align, add and restore the sign.
  assign sum = 128'(pp00_q) + (128'(pp01_q) << 32) + (128'(pp10_q) << 32)
             + (128'(pp11_q) << 64);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_o <= neg_q ? $signed(-sum) : $signed(sum);
    end
  end

endmodule

/* sv/ptp_div.sv */
`timescale 1ns / 1ps

module ptp_div import ptp_pkg::*; #(
  parameter int unsigned W     = AlphaDivW,
  parameter int unsigned STEPS = FracBits
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [W-1:0]     num_i,
  input  logic [W-1:0]     den_i,
  output logic [STEPS-1:0] quo_o
);

  // Restoring fraction divider, one quotient bit per stage.
  // The numerator must be below the denominator.
  logic [W-1:0]     rem_q [STEPS];
  logic [W-1:0]     den_q [STEPS];
  logic [STEPS-1:0] quo_q [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [W-1:0]     rem_in, den_in;
    logic [STEPS-1:0] quo_in;
    logic [W:0]       sh;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign sh = {rem_in, 1'b0};
    assign ge = sh >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? W'(sh - {1'b0, den_in}) : W'(sh);
        den_q[k] <= den_in;
        quo_q[k] <= {quo_in[STEPS-2:0], ge};
      end
    end
  end

  assign quo_o = quo_q[STEPS-1];

endmodule

/* sv/ptp_sqrt.sv */
`timescale 1ns / 1ps

module ptp_sqrt import ptp_pkg::*; #(
  parameter int unsigned ROOT_BITS = RootBits
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [2*ROOT_BITS-1:0] rad_i,
  output logic [ROOT_BITS-1:0]   root_o
);

  localparam int unsigned W = 2 * ROOT_BITS;

  // Digit-by-digit square root, one root bit per stage.
  logic [W-1:0] x_q [ROOT_BITS];
  logic [W-1:0] r_q [ROOT_BITS];

  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_step
    localparam logic [W-1:0] One = W'(1) << (2 * (ROOT_BITS - 1 - k));
    logic [W-1:0] x_in, r_in, trial;
    logic         ge;

    if (k == 0) begin : g_first
      assign x_in = rad_i;
      assign r_in = '0;
    end else begin : g_next
      assign x_in = x_q[k-1];
      assign r_in = r_q[k-1];
    end

    assign trial = r_in + One;
    assign ge    = x_in >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[k] <= ge ? x_in - trial : x_in;
        r_q[k] <= ge ? (r_in >> 1) + One : r_in >> 1;
      end
    end
  end

  assign root_o = r_q[ROOT_BITS-1][ROOT_BITS-1:0];

endmodule

/* sv/point_triangle_proximity.sv */
`timescale 1ns / 1ps

// Point to triangle proximity tester. One word (a query point and three
// vertices, Q16.16) may enter in every cycle while the output side is not
// stalled, and each gives exactly one result word. The latency is set by
// the chain of bit-serial stages: 30 stages for the barycentric division,
// 34 for the distance square root and 31 for the normal division, plus
// the Gram, determinant and closest-point stages. A stall on the output
// while a result word is held holds the whole pipeline, so stall on the
// input follows it in the same cycle. The alarm and contact registers may
// only be written while no word is in flight.
module point_triangle_proximity import ptp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  ptp_in_t     in_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output ptp_out_t    out_word_o,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [30:0] cfg_data_i
);

  typedef struct packed {
    logic [2:0]       s;
    logic [2:0][32:0] ab;
    logic [2:0][32:0] ac;
    logic [2:0][31:0] pa;
    logic [2:0][31:0] p;
  } geo_t;

  typedef struct packed {
    logic degen;
    logic rej;
    geo_t geo;
  } bary_t;

  typedef struct packed {
    logic             ok;
    logic [66:0]      norm;
    logic [2:0][31:0] q;
    logic [2:0][32:0] d;
  } nrm_t;

  typedef struct packed {
    logic             ok;
    logic             near;
    logic             dz;
    logic [2:0]       sgn;
    logic [2:0][31:0] q;
    logic [31:0]      gap;
  } fin_t;

  logic en;

  // Configuration registers and the squared alarm radius.
  logic [30:0] alarm_q, contact_q;
  logic [61:0] alarm_sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alarm_q   <= AlarmReset;
      contact_q <= ContactReset;
    end else if (cfg_we_i) begin
      unique case (ptp_reg_e'(cfg_idx_i))
        RegAlarm:   alarm_q   <= cfg_data_i;
        RegContact: contact_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    alarm_sq_q <= 62'(alarm_q) * 62'(alarm_q);
  end

  // The whole pipeline advances unless a finished word is held.
  logic out_valid_q;
  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  // Input register.
  ptp_in_t in_q;
  logic    v0_q, v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q;
  logic    v_m, v_d, v_s, v_n;

  always_ff @(posedge clk_i) begin
    if (en) in_q <= in_word_i;
  end

  // Edge vectors and the common pre-shift.
  logic signed [31:0] pt [3], va [3], vb [3], vc [3];
  logic signed [32:0] ab_c [3], ac_c [3], ap_c [3];
  logic signed [29:0] sab_c [3], sac_c [3], sap_c [3];
  logic [2:0]         s_c;
  geo_t               geo_c;

  assign pt[0] = in_q.point_x;
  assign pt[1] = in_q.point_y;
  assign pt[2] = in_q.point_z;
  assign va[0] = in_q.vertex_a_x;
  assign va[1] = in_q.vertex_a_y;
  assign va[2] = in_q.vertex_a_z;
  assign vb[0] = in_q.vertex_b_x;
  assign vb[1] = in_q.vertex_b_y;
  assign vb[2] = in_q.vertex_b_z;
  assign vc[0] = in_q.vertex_c_x;
  assign vc[1] = in_q.vertex_c_y;
  assign vc[2] = in_q.vertex_c_z;

  function automatic logic fits_at(input logic signed [32:0] v, input int unsigned sh);
    logic signed [32:0] t;
    t = v >>> (29 + sh);
    return (t == '0) || (t == '1);
  endfunction

  always_comb begin
    logic all_fit;
    for (int i = 0; i < 3; i++) begin
      ab_c[i] = $signed({vb[i][31], vb[i]}) - $signed({va[i][31], va[i]});
      ac_c[i] = $signed({vc[i][31], vc[i]}) - $signed({va[i][31], va[i]});
      ap_c[i] = $signed({pt[i][31], pt[i]}) - $signed({va[i][31], va[i]});
    end
    s_c = 3'd4;
    for (int k = 3; k >= 0; k--) begin
      all_fit = 1'b1;
      for (int i = 0; i < 3; i++) begin
        all_fit = all_fit && fits_at(ab_c[i], k) && fits_at(ac_c[i], k)
               && fits_at(ap_c[i], k);
      end
      if (all_fit) s_c = 3'(k);
    end
    for (int i = 0; i < 3; i++) begin
      sab_c[i]    = 30'(ab_c[i] >>> s_c);
      sac_c[i]    = 30'(ac_c[i] >>> s_c);
      sap_c[i]    = 30'(ap_c[i] >>> s_c);
      geo_c.ab[i] = ab_c[i];
      geo_c.ac[i] = ac_c[i];
      geo_c.pa[i] = va[i];
      geo_c.p[i]  = pt[i];
    end
    geo_c.s = s_c;
  end

  logic signed [29:0] sab_q [3], sac_q [3], sap_q [3];
  geo_t               geo1_q, geo2_q, geo3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sab_q  <= sab_c;
      sac_q  <= sac_c;
      sap_q  <= sap_c;
      geo1_q <= geo_c;
    end
  end

  // Gram products.
  logic signed [59:0] paa_q [3], pcc_q [3], pac_q [3], pab_q [3], ppc_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        paa_q[i] <= 60'(sab_q[i]) * 60'(sab_q[i]);
        pcc_q[i] <= 60'(sac_q[i]) * 60'(sac_q[i]);
        pac_q[i] <= 60'(sab_q[i]) * 60'(sac_q[i]);
        pab_q[i] <= 60'(sap_q[i]) * 60'(sab_q[i]);
        ppc_q[i] <= 60'(sap_q[i]) * 60'(sac_q[i]);
      end
      geo2_q <= geo1_q;
    end
  end

  // Gram sums.
  logic signed [61:0] a00_q, a11_q, a01_q, b0_q, b1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a00_q  <= 62'(paa_q[0]) + 62'(paa_q[1]) + 62'(paa_q[2]);
      a11_q  <= 62'(pcc_q[0]) + 62'(pcc_q[1]) + 62'(pcc_q[2]);
      a01_q  <= 62'(pac_q[0]) + 62'(pac_q[1]) + 62'(pac_q[2]);
      b0_q   <= 62'(pab_q[0]) + 62'(pab_q[1]) + 62'(pab_q[2]);
      b1_q   <= 62'(ppc_q[0]) + 62'(ppc_q[1]) + 62'(ppc_q[2]);
      geo3_q <= geo2_q;
    end
  end

  // Wide products for the determinant and the numerators.
  logic signed [127:0] m_aa, m_oo, m_ba, m_bo, m_ca, m_co;
  geo_t                geo_m;

  ptp_mul u_mul_det0 (.clk_i, .en_i(en), .a_i(64'(a00_q)), .b_i(64'(a11_q)), .p_o(m_aa));
  ptp_mul u_mul_det1 (.clk_i, .en_i(en), .a_i(64'(a01_q)), .b_i(64'(a01_q)), .p_o(m_oo));
  ptp_mul u_mul_na0  (.clk_i, .en_i(en), .a_i(64'(b0_q)),  .b_i(64'(a11_q)), .p_o(m_ba));
  ptp_mul u_mul_na1  (.clk_i, .en_i(en), .a_i(64'(b1_q)),  .b_i(64'(a01_q)), .p_o(m_bo));
  ptp_mul u_mul_nb0  (.clk_i, .en_i(en), .a_i(64'(b1_q)),  .b_i(64'(a00_q)), .p_o(m_ca));
  ptp_mul u_mul_nb1  (.clk_i, .en_i(en), .a_i(64'(b0_q)),  .b_i(64'(a01_q)), .p_o(m_co));

  ptp_delay #(.W($bits(geo_t)), .N(2)) u_dly_mul (
    .clk_i, .rst_ni, .en_i(en),
    .vld_i(v3_q), .dat_i(geo3_q), .vld_o(v_m), .dat_o(geo_m)
  );

  // Determinant, numerators and early rejection.
  logic signed [DetW-1:0] det_c, na_c, nb_c;
  logic                   degen_c, rej_c;

  assign det_c   = DetW'(m_aa - m_oo);
  assign na_c    = DetW'(m_ba - m_bo);
  assign nb_c    = DetW'(m_ca - m_co);
  assign degen_c = det_c[DetW-1] || (DetW'(det_c) <= det_thr(geo_m.s));
  assign rej_c   = na_c[DetW-1] || nb_c[DetW-1] || (na_c >= det_c) || (nb_c >= det_c);

  logic signed [DetW-1:0] det4_q, na4_q, nb4_q;
  bary_t                  side4_q, side_d;

  always_ff @(posedge clk_i) begin
    if (en) begin
      det4_q  <= det_c;
      na4_q   <= na_c;
      nb4_q   <= nb_c;
      side4_q <= '{degen: degen_c, rej: rej_c, geo: geo_m};
    end
  end

  // Barycentric coordinates in Q0.30.
  logic [FracBits-1:0] qa, qb;

  ptp_div #(.W(AlphaDivW), .STEPS(FracBits)) u_div_alpha (
    .clk_i, .en_i(en), .num_i(na4_q[AlphaDivW-1:0]), .den_i(det4_q[AlphaDivW-1:0]),
    .quo_o(qa)
  );
  ptp_div #(.W(AlphaDivW), .STEPS(FracBits)) u_div_beta (
    .clk_i, .en_i(en), .num_i(nb4_q[AlphaDivW-1:0]), .den_i(det4_q[AlphaDivW-1:0]),
    .quo_o(qb)
  );

  ptp_delay #(.W($bits(bary_t)), .N(FracBits)) u_dly_div (
    .clk_i, .rst_ni, .en_i(en),
    .vld_i(v4_q), .dat_i(side4_q), .vld_o(v_d), .dat_o(side_d)
  );

  // Degenerate fallback and interior margin test.
  logic [29:0] alpha_c, beta_c;
  logic        ok_c;

  assign alpha_c = side_d.degen ? AlphaHalf : qa;
  assign beta_c  = side_d.degen ? AlphaHalf : qb;
  assign ok_c    = side_d.degen || (!side_d.rej && (alpha_c >= MarginLo)
                 && (beta_c >= MarginLo)
                 && (({1'b0, alpha_c} + {1'b0, beta_c}) <= MarginHi));

  logic [29:0] alpha5_q, beta5_q;
  logic        ok5_q, ok6_q, ok7_q, ok8_q, ok9_q;
  geo_t        geo5_q, geo6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      alpha5_q <= alpha_c;
      beta5_q  <= beta_c;
      ok5_q    <= ok_c;
      geo5_q   <= side_d.geo;
    end
  end

  // Edge vectors scaled by the barycentric weights.
  logic signed [63:0] pra6_q [3], prb6_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pra6_q[i] <= 64'($signed(geo5_q.ab[i])) * 64'($signed({1'b0, alpha5_q}));
        prb6_q[i] <= 64'($signed(geo5_q.ac[i])) * 64'($signed({1'b0, beta5_q}));
      end
      ok6_q  <= ok5_q;
      geo6_q <= geo5_q;
    end
  end

  // Closest point, rounded half up and saturated, and its offset to the point.
  logic signed [63:0] sum_c [3];
  logic signed [34:0] qv_c [3];
  logic signed [31:0] q_c [3];
  logic signed [32:0] d_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_c[i] = pra6_q[i] + prb6_q[i];
      qv_c[i]  = 35'($signed(geo6_q.pa[i])) + 35'(sum_c[i] >>> 30)
               + 35'({1'b0, sum_c[i][29]});
      if (qv_c[i] > 35'sd2147483647) begin
        q_c[i] = 32'sh7fffffff;
      end else if (qv_c[i] < -35'sd2147483648) begin
        q_c[i] = 32'sh80000000;
      end else begin
        q_c[i] = 32'(qv_c[i]);
      end
      d_c[i] = 33'($signed(geo6_q.p[i])) - 33'(q_c[i]);
    end
  end

  logic signed [31:0] q7_q [3], q8_q [3], q9_q [3];
  logic signed [32:0] d7_q [3], d8_q [3], d9_q [3];
  logic [64:0]        sq8_q [3];
  logic [66:0]        norm9_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      q7_q  <= q_c;
      d7_q  <= d_c;
      ok7_q <= ok6_q;
    end
  end

  // Squared offsets.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq8_q[i] <= 65'(66'(d7_q[i]) * 66'(d7_q[i]));
      end
      q8_q  <= q7_q;
      d8_q  <= d7_q;
      ok8_q <= ok7_q;
    end
  end

  // Squared distance.
  always_ff @(posedge clk_i) begin
    if (en) begin
      norm9_q <= 67'(sq8_q[0]) + 67'(sq8_q[1]) + 67'(sq8_q[2]);
      q9_q    <= q8_q;
      d9_q    <= d8_q;
      ok9_q   <= ok8_q;
    end
  end

  // Distance.
  logic [RootBits-1:0] dist_root;
  nrm_t                side9_c, side_s;

  always_comb begin
    side9_c.ok   = ok9_q;
    side9_c.norm = norm9_q;
    for (int i = 0; i < 3; i++) begin
      side9_c.q[i] = q9_q[i];
      side9_c.d[i] = d9_q[i];
    end
  end

  ptp_sqrt #(.ROOT_BITS(RootBits)) u_sqrt (
    .clk_i, .en_i(en), .rad_i({1'b0, norm9_q}), .root_o(dist_root)
  );

  ptp_delay #(.W($bits(nrm_t)), .N(RootBits)) u_dly_sqrt (
    .clk_i, .rst_ni, .en_i(en),
    .vld_i(v9_q), .dat_i(side9_c), .vld_o(v_s), .dat_o(side_s)
  );

  // Alarm, gap and normal divisions by twice the distance.
  logic signed [34:0] gap_w;
  logic [31:0]        gap_c;
  logic [NrmDivW-1:0] magd_c [3];
  logic [NrmDivW-1:0] den2_c;
  fin_t               fin_c, fin_n;

  assign gap_w  = $signed({1'b0, dist_root}) - $signed(35'({1'b0, contact_q}));
  assign den2_c = NrmDivW'({dist_root, 1'b0});

  always_comb begin
    if (gap_w > 35'sd2147483647) begin
      gap_c = 32'h7fffffff;
    end else if (gap_w < -35'sd2147483648) begin
      gap_c = 32'h80000000;
    end else begin
      gap_c = 32'(gap_w);
    end
    fin_c.ok   = side_s.ok;
    fin_c.near = side_s.norm < 67'(alarm_sq_q);
    fin_c.dz   = (dist_root == '0);
    fin_c.gap  = gap_c;
    for (int i = 0; i < 3; i++) begin
      fin_c.sgn[i] = side_s.d[i][32];
      fin_c.q[i]   = side_s.q[i];
      magd_c[i]    = side_s.d[i][32] ? NrmDivW'(-$signed(side_s.d[i]))
                                      : NrmDivW'(side_s.d[i]);
    end
  end

  logic [NrmSteps-1:0] mq [3];

  for (genvar i = 0; i < 3; i++) begin : g_nrm
    ptp_div #(.W(NrmDivW), .STEPS(NrmSteps)) u_div_nrm (
      .clk_i, .en_i(en), .num_i(magd_c[i]), .den_i(den2_c), .quo_o(mq[i])
    );
  end

  ptp_delay #(.W($bits(fin_t)), .N(NrmSteps)) u_dly_nrm (
    .clk_i, .rst_ni, .en_i(en),
    .vld_i(v_s), .dat_i(fin_c), .vld_o(v_n), .dat_o(fin_n)
  );

  // Result word, cleared when the projection is rejected.
  logic signed [31:0] nrm_c [3];
  ptp_out_t           out_d, out_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (fin_n.dz) begin
        nrm_c[i] = '0;
      end else if (fin_n.sgn[i]) begin
        nrm_c[i] = -$signed(32'(mq[i]));
      end else begin
        nrm_c[i] = $signed(32'(mq[i]));
      end
    end
    out_d = '0;
    if (fin_n.ok) begin
      out_d.contact_valid = 1'b1;
      out_d.near_alarm    = fin_n.near;
      out_d.closest_x     = fin_n.q[0];
      out_d.closest_y     = fin_n.q[1];
      out_d.closest_z     = fin_n.q[2];
      out_d.normal_x      = nrm_c[0];
      out_d.normal_y      = nrm_c[1];
      out_d.normal_z      = nrm_c[2];
      out_d.signed_gap    = fin_n.gap;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) out_q <= out_d;
  end

  // Valid bits of the stages held in this module.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q        <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      v6_q        <= 1'b0;
      v7_q        <= 1'b0;
      v8_q        <= 1'b0;
      v9_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v0_q        <= in_valid_i;
      v1_q        <= v0_q;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v_m;
      v5_q        <= v_d;
      v6_q        <= v5_q;
      v7_q        <= v6_q;
      v8_q        <= v7_q;
      v9_q        <= v8_q;
      out_valid_q <= v_n;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule
